// ===== rtl/core/tcs_pkg.sv =====
// ----------------------------------------------------------------------------
// tcs_pkg: shared types and constants for the traffic countdown display
// widths, field codes and the seven-segment glyph table
// ----------------------------------------------------------------------------
package tcs_pkg;

    localparam int NUM_DIGITS = 4;
    localparam int IDX_W      = 2;
    localparam int TIME_W     = 7;
    localparam int CNT_W      = 9;
    localparam int DIGIT_W    = 4;
    localparam int SEG_W      = 7;

    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [TIME_W-1:0]     t_time;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [DIGIT_W-1:0]    t_digit;
    typedef logic [SEG_W-1:0]      t_seg;
    typedef logic [NUM_DIGITS-1:0] t_enables;

    typedef enum logic {
        ACT_TICK = 1'b0,
        ACT_SCAN = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_RED    = 2'd1,
        MODE_AMBER  = 2'd2,
        MODE_GREEN  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CFG_RED   = 2'd0,
        CFG_AMBER = 2'd1,
        CFG_GREEN = 2'd2
    } t_cfg_idx;

    // digit shown left of the set-up value
    localparam t_digit SETUP_DIGIT_RED   = 4'd2;
    localparam t_digit SETUP_DIGIT_AMBER = 4'd3;
    localparam t_digit SETUP_DIGIT_GREEN = 4'd4;

    localparam t_time RED_RESET   = 7'd5;
    localparam t_time AMBER_RESET = 7'd2;
    localparam t_time GREEN_RESET = 7'd3;

    localparam t_seg SEG_BLANK = 7'h7F;

    typedef struct packed {
        t_digit tens;
        t_digit units;
    } t_pair;

    // active-low glyphs for 0..9, blank otherwise
    function automatic t_seg seg_glyph(input t_digit d);
        t_seg s;
        case (d)
            4'd0:    s = 7'h40;
            4'd1:    s = 7'h79;
            4'd2:    s = 7'h24;
            4'd3:    s = 7'h30;
            4'd4:    s = 7'h19;
            4'd5:    s = 7'h12;
            4'd6:    s = 7'h02;
            4'd7:    s = 7'h78;
            4'd8:    s = 7'h00;
            4'd9:    s = 7'h10;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    // tens and units of a 9-bit value; x*205>>11 equals x/10 below 1029
    function automatic t_pair split_pair(input t_cnt v);
        logic [CNT_W+7:0] prod;
        logic [5:0]       tens_full;
        logic [CNT_W-1:0] tens_x10;
        logic [CNT_W-1:0] rem;
        t_pair            p;
        prod      = {8'd0, v} * (CNT_W+8)'(205);
        tens_full = prod[CNT_W+7:11];
        tens_x10  = CNT_W'({tens_full, 3'b000}) + CNT_W'({tens_full, 1'b0});
        rem       = v - tens_x10;
        p.units   = rem[DIGIT_W-1:0];
        p.tens    = (tens_full > 6'd15) ? 4'd15 : tens_full[DIGIT_W-1:0];
        return p;
    endfunction

endpackage

// ===== rtl/core/tcs_ifs.sv =====
// ----------------------------------------------------------------------------
// tcs channel interfaces
// valid/ready channels for input words, result words and register writes
// ----------------------------------------------------------------------------
interface tcs_in_if;
    import tcs_pkg::*;
    logic  valid;
    logic  ready;
    logic  action;
    logic  [1:0] display_mode;
    t_idx  digit_index;

    modport source (output valid, output action, output display_mode,
                    output digit_index, input ready);
    modport sink   (input valid, input action, input display_mode,
                    input digit_index, output ready);
endinterface

interface tcs_out_if;
    import tcs_pkg::*;
    logic     valid;
    logic     ready;
    t_seg     segments_n;
    t_enables enables_n;
    t_idx     next_digit;

    modport source (output valid, output segments_n, output enables_n,
                    output next_digit, input ready);
    modport sink   (input valid, input segments_n, input enables_n,
                    input next_digit, output ready);
endinterface

interface tcs_cfg_if;
    import tcs_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] reg_index;
    t_time      wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== rtl/core/traffic_countdown_seven_seg_scan_core.sv =====
// ----------------------------------------------------------------------------
// traffic_countdown_seven_seg_scan_core
// two-road countdown into a four-digit buffer, scanned one digit per word
// ----------------------------------------------------------------------------
// a scan word passes the stage register, then the result register
// throughput: one word per cycle while the result side is ready; the stage register
//   plus the result register let a new word enter while a result waits
// tick words give no result; they update the digit buffer, and in normal mode the
//   counters, as they leave the stage register
// reset (synchronous, active low): times 5/2/3, both counters 1, digits 1,2,3,4
module traffic_countdown_seven_seg_scan_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tcs_in_if.sink        i_in,
    tcs_cfg_if.sink       i_cfg,
    tcs_out_if.source     o_out
);
    import tcs_pkg::*;

    // configuration registers
    t_time r_red, r_amber, r_green;

    // road counters and the display buffer
    t_cnt   r_land_cnt, r_port_cnt;
    t_cnt   n_land_cnt, n_port_cnt;
    t_digit r_digits [NUM_DIGITS];
    t_digit n_digits [NUM_DIGITS];

    // stage register holding the accepted word
    logic    r_s1_valid;
    t_action r_s1_action;
    t_mode   r_s1_mode;
    t_idx    r_s1_idx;

    // result register
    logic     r_out_valid;
    t_seg     r_out_seg;
    t_enables r_out_en;
    t_idx     r_out_next;

    logic  s1_is_scan;
    logic  out_free;
    logic  s1_fire;
    logic  in_fire;
    logic  tick_fire;

    t_cnt  red_x, amber_x, green_x;
    t_cnt  total;
    t_cnt  land_v, port_v, setup_v;
    t_pair land_p, port_p, setup_p;

    t_digit scan_digit;

    // ---------------- handshake ----------------
    assign s1_is_scan = (r_s1_action == ACT_SCAN);
    assign out_free   = !r_out_valid || o_out.ready;
    // a tick never waits for the result side
    assign s1_fire    = r_s1_valid && (!s1_is_scan || out_free);
    assign in_fire    = i_in.valid && i_in.ready;
    assign tick_fire  = s1_fire && !s1_is_scan;

    assign i_in.ready  = !r_s1_valid || s1_fire;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_action <= t_action'(i_in.action);
            r_s1_mode   <= t_mode'(i_in.display_mode);
            r_s1_idx    <= i_in.digit_index;
        end
    end

    // ---------------- configuration writes ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red   <= RED_RESET;
            r_amber <= AMBER_RESET;
            r_green <= GREEN_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                CFG_RED:   r_red   <= i_cfg.wdata;
                CFG_AMBER: r_amber <= i_cfg.wdata;
                CFG_GREEN: r_green <= i_cfg.wdata;
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // ---------------- tick datapath ----------------
    assign red_x   = CNT_W'(r_red);
    assign amber_x = CNT_W'(r_amber);
    assign green_x = CNT_W'(r_green);
    assign total   = red_x + amber_x + green_x;

    always_comb begin
        // landscape road: red, then green, then amber
        if (r_land_cnt <= red_x) begin
            land_v = red_x - r_land_cnt;
        end else if (r_land_cnt <= red_x + green_x) begin
            land_v = red_x + green_x - r_land_cnt;
        end else if (r_land_cnt <= total) begin
            land_v = total - r_land_cnt;
        end else begin
            land_v = '0;  // counter beyond a shortened cycle
        end

        // portrait road: green, then amber, then red
        if (r_port_cnt <= green_x) begin
            port_v = green_x - r_port_cnt;
        end else if (r_port_cnt <= amber_x + green_x) begin
            port_v = amber_x + green_x - r_port_cnt;
        end else if (r_port_cnt <= total) begin
            port_v = total - r_port_cnt;
        end else begin
            port_v = '0;
        end
    end

    always_comb begin
        case (r_s1_mode)
            MODE_RED:   setup_v = red_x;
            MODE_AMBER: setup_v = amber_x;
            default:    setup_v = green_x;
        endcase
    end

    assign land_p  = split_pair(land_v);
    assign port_p  = split_pair(port_v);
    assign setup_p = split_pair(setup_v);

    // counter advance: wrap to 1 past the cycle end or on 9-bit overflow
    always_comb begin
        n_land_cnt = r_land_cnt + CNT_W'(1);
        if (n_land_cnt > total || n_land_cnt == '0) begin
            n_land_cnt = CNT_W'(1);
        end
        n_port_cnt = r_port_cnt + CNT_W'(1);
        if (n_port_cnt > total || n_port_cnt == '0) begin
            n_port_cnt = CNT_W'(1);
        end
    end

    always_comb begin
        unique case (r_s1_mode)
            MODE_NORMAL: begin
                n_digits[0] = land_p.tens;
                n_digits[1] = land_p.units;
                n_digits[2] = port_p.tens;
                n_digits[3] = port_p.units;
            end
            MODE_RED: begin
                n_digits[0] = '0;
                n_digits[1] = SETUP_DIGIT_RED;
                n_digits[2] = setup_p.tens;
                n_digits[3] = setup_p.units;
            end
            MODE_AMBER: begin
                n_digits[0] = '0;
                n_digits[1] = SETUP_DIGIT_AMBER;
                n_digits[2] = setup_p.tens;
                n_digits[3] = setup_p.units;
            end
            default: begin
                n_digits[0] = '0;
                n_digits[1] = SETUP_DIGIT_GREEN;
                n_digits[2] = setup_p.tens;
                n_digits[3] = setup_p.units;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_land_cnt <= CNT_W'(1);
            r_port_cnt <= CNT_W'(1);
            for (int i = 0; i < NUM_DIGITS; i++) begin
                r_digits[i] <= DIGIT_W'(i + 1);
            end
        end else if (tick_fire) begin
            // set-up ticks leave the counters alone
            if (r_s1_mode == MODE_NORMAL) begin
                r_land_cnt <= n_land_cnt;
                r_port_cnt <= n_port_cnt;
            end
            for (int i = 0; i < NUM_DIGITS; i++) begin
                r_digits[i] <= n_digits[i];
            end
        end
    end

    // ---------------- scan datapath and result register ----------------
    assign scan_digit = r_digits[r_s1_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && s1_is_scan) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && s1_is_scan) begin
            r_out_seg  <= seg_glyph(scan_digit);
            r_out_en   <= ~(t_enables'(1) << r_s1_idx);
            r_out_next <= r_s1_idx + IDX_W'(1);  // wraps over four digits
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.segments_n = r_out_seg;
    assign o_out.enables_n  = r_out_en;
    assign o_out.next_digit = r_out_next;

    // ---------------- checks ----------------
    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_land_cnt != '0 && r_port_cnt != '0)
        else $error("road counter reached zero");

    a_scan_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && s1_is_scan) |=> r_out_valid)
        else $error("scan word left the stage without a result");

    a_setup_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tick_fire && r_s1_mode != MODE_NORMAL) |=>
            ($stable(r_land_cnt) && $stable(r_port_cnt)))
        else $error("set-up tick moved a counter");

    a_one_cold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot(~r_out_en))
        else $error("digit enables not one-cold");

    a_no_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !(s1_fire && s1_is_scan))
        else $error("scan result would overwrite a pending word");

endmodule

// ===== bench/tb_traffic_countdown_seven_seg_scan_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_traffic_countdown_seven_seg_scan_core
// drives tick and scan words plus register writes into the countdown core,
// keeps its own copy of the counters and digit buffer, and checks every
// scan word against the glyph, enable and next digit that copy predicts
// ----------------------------------------------------------------------------
module tb_traffic_countdown_seven_seg_scan_core;
    import tcs_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 5;
    // scan words pass the stage and result registers, ticks only the stage register;
    // settle after the last word before register writes
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_WORDS  = 950;
    localparam int MAX_REPORTS   = 10;

    // unmapped register index, a write there must change nothing
    localparam logic [1:0] CFG_SPARE = 2'd3;

    // active-low glyphs for digits 0..9
    localparam t_seg GLYPH_ROM [0:9] = '{7'h40, 7'h79, 7'h24, 7'h30, 7'h19,
                                         7'h12, 7'h02, 7'h78, 7'h00, 7'h10};

    typedef struct packed {
        t_seg     segments_n;
        t_enables enables_n;
        t_idx     next_digit;
    } t_scan_word;

    logic clk;
    logic rst_n;

    tcs_in_if  in_ch ();
    tcs_cfg_if cfg_ch ();
    tcs_out_if out_ch ();

    traffic_countdown_seven_seg_scan_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // predicted block state: phase times, road counters, digit buffer
    t_time  red_ticks;
    t_time  amber_ticks;
    t_time  green_ticks;
    t_cnt   land_pos;
    t_cnt   port_pos;
    t_digit shown [NUM_DIGITS];

    // scan words still owed by the block, oldest first
    t_scan_word glyph_queue [$];

    int  mismatches;
    int  ticks_sent;
    int  scans_sent;
    int  reg_writes;
    int  settings_used;
    int  cycles;
    int  stall_left;
    bit  bursts_on;

    // ------------------------------------------------------------------------
    // clock and watchdog
    // ------------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d scan words outstanding",
                     cycles, glyph_queue.size());
            $display("traffic_countdown_seven_seg_scan_core test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // time left for one road: first phase, then second, then the rest of the
    // cycle; a counter past the end of the cycle shows zero
    function automatic int road_left(int c, int first, int second, int total);
        if (c <= first)
            return first - c;
        else if (c <= first + second)
            return first + second - c;
        else if (c <= total)
            return total - c;
        return 0;
    endfunction

    // counter is 9 bits wide and wraps back to 1 past the cycle length
    function automatic t_cnt next_pos(t_cnt c, int total);
        int n;
        n = (int'(c) + 1) & 'h1FF;
        if (n > total || n == 0)
            n = 1;
        return t_cnt'(n);
    endfunction

    // tens and units into two neighboring digits, tens clamped to one nibble
    function automatic void put_time(int pos, int v);
        int tens;
        tens = v / 10;
        if (tens > 15)
            tens = 15;
        shown[pos]     = t_digit'(tens);
        shown[pos + 1] = t_digit'(v % 10);
    endfunction

    function automatic void apply_tick(t_mode mode);
        int r;
        int a;
        int g;
        int total;
        r = red_ticks;
        a = amber_ticks;
        g = green_ticks;
        total = r + a + g;
        case (mode)
            MODE_NORMAL: begin
                // landscape runs red, green, amber; portrait green, amber, red
                put_time(0, road_left(land_pos, r, g, total));
                land_pos = next_pos(land_pos, total);
                put_time(2, road_left(port_pos, g, a, total));
                port_pos = next_pos(port_pos, total);
            end
            MODE_RED: begin
                shown[0] = 4'd0;
                shown[1] = SETUP_DIGIT_RED;
                put_time(2, r);
            end
            MODE_AMBER: begin
                shown[0] = 4'd0;
                shown[1] = SETUP_DIGIT_AMBER;
                put_time(2, a);
            end
            default: begin
                shown[0] = 4'd0;
                shown[1] = SETUP_DIGIT_GREEN;
                put_time(2, g);
            end
        endcase
    endfunction

    function automatic t_scan_word scan_result(t_idx idx);
        t_scan_word w;
        t_digit     d;
        d = shown[idx];
        // digits 10..15 have no glyph and go dark
        w.segments_n = (d < 4'd10) ? GLYPH_ROM[d] : SEG_BLANK;
        w.enables_n  = ~(t_enables'(1) << idx);
        w.next_digit = idx + 1'b1;
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // result side: random stall bursts
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n || !bursts_on) begin
            out_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 5);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // every accepted scan word against the oldest prediction
    always @(posedge clk) begin : check_scan_words
        t_scan_word got;
        t_scan_word want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got.segments_n = out_ch.segments_n;
            got.enables_n  = out_ch.enables_n;
            got.next_digit = out_ch.next_digit;
            if (glyph_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("cycle %0d: unexpected scan word seg %h en %b next %0d",
                             cycles, got.segments_n, got.enables_n, got.next_digit);
            end else begin
                want = glyph_queue.pop_front();
                if (got.segments_n !== want.segments_n ||
                    got.enables_n  !== want.enables_n  ||
                    got.next_digit !== want.next_digit) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("cycle %0d: scan word mismatch, expected seg %h en %b next %0d",
                                 cycles, want.segments_n, want.enables_n,
                                 want.next_digit);
                        $display("    got seg %h en %b next %0d",
                                 got.segments_n, got.enables_n, got.next_digit);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // one word, with an optional idle burst ahead of it; valid stays high
    // after acceptance so back-to-back words follow without a gap
    task automatic send_word(t_action act, t_mode mode, t_idx idx);
        if (bursts_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.action       <= act;
        in_ch.display_mode <= mode;
        in_ch.digit_index  <= idx;
        do @(posedge clk); while (!in_ch.ready);
        if (act == ACT_TICK) begin
            apply_tick(mode);
            ticks_sent++;
        end else begin
            glyph_queue.push_back(scan_result(idx));
            scans_sent++;
        end
    endtask

    // scan a run of digits in display order; mode field is noise on scans
    task automatic scan_digits(t_idx first, int count);
        t_idx idx;
        idx = first;
        repeat (count) begin
            send_word(ACT_SCAN, t_mode'($urandom_range(0, 3)), idx);
            idx++;
        end
    endtask

    // drop valid, let all owed words drain, then let a trailing tick settle
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (glyph_queue.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, t_time value);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wdata     <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            CFG_RED:   red_ticks   = value;
            CFG_AMBER: amber_ticks = value;
            CFG_GREEN: green_ticks = value;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic program_times(t_time r, t_time a, t_time g, bit spare_too);
        wait_idle();
        write_reg(CFG_RED, r);
        write_reg(CFG_AMBER, a);
        write_reg(CFG_GREEN, g);
        if (spare_too)
            write_reg(CFG_SPARE, t_time'($urandom_range(0, 127)));
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    function automatic t_time pick_extreme();
        case ($urandom_range(0, 3))
            0:       return 7'd0;
            1:       return 7'd1;
            2:       return 7'd99;
            default: return 7'd127;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // buffer straight out of reset holds 1, 2, 3, 4
    task automatic test_reset_digits();
        scan_digits(2'd0, NUM_DIGITS);
    endtask

    // set-up ticks show 0, the mode digit and the duration; index is noise
    task automatic test_setup_modes();
        send_word(ACT_TICK, MODE_RED, 2'd3);
        scan_digits(2'd0, NUM_DIGITS);
        send_word(ACT_TICK, MODE_AMBER, 2'd1);
        scan_digits(2'd3, 1);
        send_word(ACT_TICK, MODE_GREEN, 2'd2);
        scan_digits(2'd1, 1);
    endtask

    // two normal ticks with the reset times, then the whole buffer
    task automatic test_normal_countdown();
        send_word(ACT_TICK, MODE_NORMAL, 2'd2);
        send_word(ACT_TICK, MODE_NORMAL, 2'd0);
        scan_digits(2'd0, NUM_DIGITS);
    endtask

    // widest and zero durations; tens of 12 has no glyph; zero times leave
    // both counters past the cycle end so each road shows 00 and restarts
    task automatic test_register_extremes();
        program_times(7'd127, 7'd0, 7'd127, 1'b1);
        send_word(ACT_TICK, MODE_RED, 2'd0);
        scan_digits(2'd2, 2);
        send_word(ACT_TICK, MODE_NORMAL, 2'd3);
        scan_digits(2'd0, 2);
        program_times(7'd0, 7'd0, 7'd0, 1'b0);
        send_word(ACT_TICK, MODE_NORMAL, 2'd1);
        scan_digits(2'd3, 2);
    endtask

    // phases of random settings; mostly normal ticks each followed by a run
    // of scans, some set-up ticks, and a little fully random noise
    task automatic test_random_traffic();
        int    base;
        int    sent;
        int    quiet_from;
        int    phase_left;
        int    pick;
        t_time r;
        t_time a;
        t_time g;
        base = ticks_sent + scans_sent;
        sent = 0;
        quiet_from = RANDOM_WORDS * 7 / 8;
        while (sent < RANDOM_WORDS) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                r = pick_extreme();
                a = pick_extreme();
                g = pick_extreme();
            end else if (pick < 3) begin
                r = t_time'($urandom_range(1, 99));
                a = t_time'($urandom_range(1, 99));
                g = t_time'($urandom_range(1, 99));
            end else begin
                // short cycles so the counters wrap many times per phase
                r = t_time'($urandom_range(1, 9));
                a = t_time'($urandom_range(1, 9));
                g = t_time'($urandom_range(1, 9));
            end
            if (sent >= quiet_from)
                bursts_on = 1'b0;
            program_times(r, a, g, $urandom_range(0, 3) == 0);
            phase_left = $urandom_range(60, 120);
            while (phase_left > 0 && sent < RANDOM_WORDS) begin
                if (sent >= quiet_from)
                    bursts_on = 1'b0;
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    send_word(ACT_TICK, MODE_NORMAL, t_idx'($urandom_range(0, 3)));
                    scan_digits(t_idx'($urandom_range(0, 3)), $urandom_range(1, 4));
                end else if (pick < 9) begin
                    send_word(ACT_TICK, t_mode'($urandom_range(MODE_RED, MODE_GREEN)),
                              t_idx'($urandom_range(0, 3)));
                    scan_digits(t_idx'($urandom_range(0, 3)), $urandom_range(1, 4));
                end else begin
                    send_word(t_action'($urandom_range(0, 1)),
                              t_mode'($urandom_range(0, 3)),
                              t_idx'($urandom_range(0, 3)));
                end
                phase_left -= (ticks_sent + scans_sent - base) - sent;
                sent = ticks_sent + scans_sent - base;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        rst_n               = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.action        = ACT_TICK;
        in_ch.display_mode  = MODE_NORMAL;
        in_ch.digit_index   = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.reg_index    = CFG_RED;
        cfg_ch.wdata        = '0;
        bursts_on           = 1'b1;
        ticks_sent          = 0;
        scans_sent          = 0;
        reg_writes          = 0;
        settings_used       = 0;

        // state the block comes out of reset with
        red_ticks   = RED_RESET;
        amber_ticks = AMBER_RESET;
        green_ticks = GREEN_RESET;
        land_pos    = t_cnt'(1);
        port_pos    = t_cnt'(1);
        for (int i = 0; i < NUM_DIGITS; i++)
            shown[i] = t_digit'(i + 1);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_digits();
        test_setup_modes();
        test_normal_countdown();
        test_register_extremes();
        test_random_traffic();

        // everything owed must arrive, then watch for strays a while
        wait_idle();

        $display("covered %0d tick words and %0d scan words across %0d timing settings",
                 ticks_sent, scans_sent, settings_used);
        $display("%0d register writes, %0d mismatching or stray scan words",
                 reg_writes, mismatches);
        if (mismatches == 0)
            $display("traffic_countdown_seven_seg_scan_core test passed");
        else
            $display("traffic_countdown_seven_seg_scan_core test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/tcs_pkg.sv
rtl/core/tcs_ifs.sv
rtl/core/traffic_countdown_seven_seg_scan_core.sv
bench/tb_traffic_countdown_seven_seg_scan_core.sv
